[rtl/core/nrmc_pkg.sv]
// ----------------------------------------------------------------------------
// nrmc_pkg: shared types and constants of the RMC sentence parser
// Holds the character codes, field positions, result status codes, the
// fixed-point conversion constants and the records passed between stages.
// ----------------------------------------------------------------------------
package nrmc_pkg;

  // Line length limit and number of fraction digits kept per field.
  localparam int MAX_LINE    = 128;
  localparam int FRAC_DIGITS = 4;
  localparam int LC_W        = $clog2(MAX_LINE);

  // Result status codes.
  localparam logic [1:0] ST_VALID     = 2'd0;
  localparam logic [1:0] ST_VOID      = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_NOT_RMC   = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_A     = 8'd65;
  localparam logic [7:0] CH_S     = 8'd83;
  localparam logic [7:0] CH_W     = 8'd87;

  // Field positions within the sentence.
  localparam logic [3:0] FLD_ID     = 4'd0;
  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_SPEED  = 4'd7;
  localparam logic [3:0] FLD_COURSE = 4'd8;
  localparam logic [3:0] FLD_LAST   = 4'd15;

  // Range limits of the results.
  localparam longint unsigned TIME_MAX   = 64'd23595999;
  localparam longint unsigned LAT_MAX    = 64'd900000000;
  localparam longint unsigned LON_MAX    = 64'd1800000000;
  localparam longint unsigned SPEED_MAX  = 64'd1852000;
  localparam longint unsigned HEAD_MAX   = 64'd36000;
  localparam longint unsigned DEG_SCALE  = 64'd10000000;

  // Scale of one field value and the saturating width of field values.
  // The width covers the largest value below which any conversion still
  // gives an unclamped result, so saturating there changes no result.
  localparam longint unsigned PW      = 64'd10 ** FRAC_DIGITS;
  localparam longint unsigned CENTI_D = PW / 100;
  localparam int V_W     = $clog2((TIME_MAX + 1) * CENTI_D + 1);
  localparam logic [V_W-1:0] V_CAP = '1;
  localparam int SCALE_W = $clog2(PW + 1);

  // Divide by CENTI_D through a reciprocal (time and heading).
  localparam int T_SH = V_W + $clog2(CENTI_D);
  localparam logic [V_W:0] T_MUL = (V_W+1)'(((64'd1 << T_SH) + CENTI_D - 1) / CENTI_D);

  // Degrees-minutes split and minutes to degrees.
  localparam longint unsigned DEG_D   = 64'd100 * PW;
  localparam longint unsigned DEG_LIM = 64'd1000 * DEG_D;
  localparam int DEG_W = 10;
  localparam int D_SH  = V_W + $clog2(DEG_D);
  localparam logic [V_W:0] D_MUL = (V_W+1)'(((64'd1 << D_SH) + DEG_D - 1) / DEG_D);
  localparam longint unsigned DEG_K = 64'd10 ** (6 - FRAC_DIGITS);
  localparam int M_W   = $clog2(DEG_D);
  localparam int N_W   = $clog2(DEG_D * DEG_K + 4);
  localparam int Q6_SH = N_W + 3;
  localparam logic [N_W:0] Q6_MUL = (N_W+1)'(((64'd1 << Q6_SH) + 5) / 6);

  // Knots to km/h: split at 10*PW, then round the low part.
  localparam longint unsigned SPD_D   = 64'd10 * PW;
  localparam longint unsigned SPD_LIM = 64'd10000 * PW;
  localparam longint unsigned SPD_RND = 64'd5 * PW / 4;
  localparam longint unsigned Q_D     = 64'd10 * PW / 4;
  localparam int VH_W  = 10;
  localparam int VL_W  = $clog2(SPD_D);
  localparam int S1_SH = V_W + $clog2(SPD_D);
  localparam logic [V_W:0] S1_MUL = (V_W+1)'(((64'd1 << S1_SH) + SPD_D - 1) / SPD_D);
  localparam int N2_W  = $clog2(64'd463 * SPD_D + SPD_RND + 1);
  localparam int S2_SH = N2_W + $clog2(Q_D);
  localparam logic [N2_W:0] S2_MUL = (N2_W+1)'(((64'd1 << S2_SH) + Q_D - 1) / Q_D);

  // Per-line flags.
  typedef struct packed {
    logic prefix;
    logic time_ok;
    logic time_bad;
    logic fix;
    logic lat_ok;
    logic lat_s;
    logic lon_ok;
    logic lon_w;
    logic spd_ok;
    logic hdg_ok;
    logic err;
  } flags_t;

  // One finished line with its raw scaled field values.
  typedef struct packed {
    flags_t           flags;
    logic [V_W-1:0]   time_raw;
    logic [V_W-1:0]   lat_raw;
    logic [V_W-1:0]   lon_raw;
    logic [V_W-1:0]   spd_raw;
    logic [V_W-1:0]   hdg_raw;
  } line_t;

  // One line with its converted values.
  typedef struct packed {
    flags_t       flags;
    logic [24:0]  time_c;
    logic [29:0]  lat_mag;
    logic [30:0]  lon_mag;
    logic [20:0]  spd_c;
    logic [15:0]  hdg_c;
  } conv_t;

  // Expected characters of the sentence identifier.
  function automatic logic [7:0] rmc_id_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Ten to the power k, for k up to FRAC_DIGITS.
  function automatic logic [SCALE_W-1:0] pow10_scale(input logic [2:0] k);
    logic [SCALE_W-1:0] p;
    p = SCALE_W'(1);
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      if (i < int'(k)) p = SCALE_W'(p * 10);
    end
    return p;
  endfunction

endpackage

[rtl/core/nmea_rmc_sentence_parser_unit.sv]
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser_unit: NMEA RMC sentence parser, top level
// Takes text one byte per word and gives one fixed-point result word
// for every line end.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid / in_stall  | rx_byte
//   out     | output    | out_valid / out_stall| status, utc_time_centi,
//           |           |                      | latitude_e7, longitude_e7,
//           |           |                      | speed_kmh_centi, heading_centi
//
// One byte word is taken every cycle while in_stall is low; a line end gives its result word
// through the line register, five conversion stages and the output register.
// Synchronous reset clears the line state, the pipeline and the held fix.
// While a result word waits under out_stall the whole pipeline holds and
// in_stall is raised; a free output register lets the pipeline move on.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [24:0]         utc_time_centi,
  output logic signed [30:0]  latitude_e7,
  output logic signed [31:0]  longitude_e7,
  output logic [20:0]         speed_kmh_centi,
  output logic [15:0]         heading_centi
);

  logic             adv;
  logic             accept;
  logic             line_vld;
  nrmc_pkg::line_t  line_rec;
  logic             conv_vld;
  nrmc_pkg::conv_t  conv_rec;

  // The pipeline moves whenever the output register is free or taken.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  nrmc_line_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .line_vld (line_vld),
    .line_rec (line_rec)
  );

  nrmc_convert u_convert (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (line_vld),
    .in_rec  (line_rec),
    .out_vld (conv_vld),
    .out_rec (conv_rec)
  );

  nrmc_result u_result (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .in_vld          (conv_vld),
    .in_rec          (conv_rec),
    .out_valid       (out_valid),
    .status          (status),
    .utc_time_centi  (utc_time_centi),
    .latitude_e7     (latitude_e7),
    .longitude_e7    (longitude_e7),
    .speed_kmh_centi (speed_kmh_centi),
    .heading_centi   (heading_centi)
  );

endmodule

[rtl/core/nrmc_line_parser.sv]
// ----------------------------------------------------------------------------
// nrmc_line_parser: byte-level field splitter and number accumulator
// Splits a line at commas, accumulates digits of the current field and
// registers the finished line record when LF arrives.
// ----------------------------------------------------------------------------
module nrmc_line_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output logic                line_vld,
  output nrmc_pkg::line_t     line_rec
);

  logic [3:0]                    field_number;
  logic [nrmc_pkg::LC_W-1:0]     line_count;
  logic [nrmc_pkg::V_W-1:0]      acc;
  logic [2:0]                    frac_digits;
  logic                          seen_point;
  logic                          id_bad;
  logic [2:0]                    fld_len;
  logic [7:0]                    fld_first;
  logic                          fld_bad;
  nrmc_pkg::line_t               rec;

  logic [2:0]                              scale_k;
  logic [nrmc_pkg::SCALE_W-1:0]            scale_f;
  logic [nrmc_pkg::V_W+nrmc_pkg::SCALE_W-1:0] scaled_wide;
  logic [nrmc_pkg::V_W-1:0]                scaled;
  logic [nrmc_pkg::V_W+3:0]                acc_wide;
  logic [nrmc_pkg::V_W-1:0]                acc_next;
  logic                                    present;
  logic                                    is_digit;
  logic                                    numeric;
  nrmc_pkg::line_t                         rec_fin;

  // Scale the field value to FRAC_DIGITS places and close the field.
  always_comb begin
    scale_k     = 3'(nrmc_pkg::FRAC_DIGITS) - frac_digits;
    scale_f     = nrmc_pkg::pow10_scale(scale_k);
    scaled_wide = (nrmc_pkg::V_W+nrmc_pkg::SCALE_W)'(acc) *
                  (nrmc_pkg::V_W+nrmc_pkg::SCALE_W)'(scale_f);
    scaled      = (scaled_wide > (nrmc_pkg::V_W+nrmc_pkg::SCALE_W)'(nrmc_pkg::V_CAP)) ?
                  nrmc_pkg::V_CAP : nrmc_pkg::V_W'(scaled_wide);
    present     = (fld_len != 3'd0);
    numeric     = (field_number == nrmc_pkg::FLD_LAT) || (field_number == nrmc_pkg::FLD_LON) ||
                  (field_number == nrmc_pkg::FLD_SPEED) ||
                  (field_number == nrmc_pkg::FLD_COURSE);
    rec_fin = rec;
    if (numeric && fld_bad) rec_fin.flags.err = 1'b1;
    case (field_number)
      nrmc_pkg::FLD_ID: begin
        rec_fin.flags.prefix = !id_bad && (fld_len == 3'd6);
      end
      nrmc_pkg::FLD_TIME: begin
        rec_fin.flags.time_ok  = present;
        rec_fin.flags.time_bad = fld_bad;
        rec_fin.time_raw       = scaled;
      end
      nrmc_pkg::FLD_STATUS: begin
        rec_fin.flags.fix = present && (fld_first == nrmc_pkg::CH_A);
      end
      nrmc_pkg::FLD_LAT: begin
        rec_fin.flags.lat_ok = present;
        rec_fin.lat_raw      = scaled;
      end
      nrmc_pkg::FLD_NS: begin
        rec_fin.flags.lat_s = present && (fld_first == nrmc_pkg::CH_S);
      end
      nrmc_pkg::FLD_LON: begin
        rec_fin.flags.lon_ok = present;
        rec_fin.lon_raw      = scaled;
      end
      nrmc_pkg::FLD_EW: begin
        rec_fin.flags.lon_w = present && (fld_first == nrmc_pkg::CH_W);
      end
      nrmc_pkg::FLD_SPEED: begin
        rec_fin.flags.spd_ok = present;
        rec_fin.spd_raw      = scaled;
      end
      nrmc_pkg::FLD_COURSE: begin
        rec_fin.flags.hdg_ok = present;
        rec_fin.hdg_raw      = scaled;
      end
      default: begin
      end
    endcase
  end

  // Next accumulator value for a digit, saturating.
  always_comb begin
    is_digit = rx_byte inside {[nrmc_pkg::CH_0:nrmc_pkg::CH_9]};
    acc_wide = (nrmc_pkg::V_W+4)'(acc) * (nrmc_pkg::V_W+4)'(10) +
               (nrmc_pkg::V_W+4)'(rx_byte - nrmc_pkg::CH_0);
    acc_next = (acc_wide > (nrmc_pkg::V_W+4)'(nrmc_pkg::V_CAP)) ?
               nrmc_pkg::V_CAP : nrmc_pkg::V_W'(acc_wide);
  end

  // Line and field state.
  always_ff @(posedge clk) begin
    if (rst) begin
      field_number <= '0;
      line_count   <= '0;
      acc          <= '0;
      frac_digits  <= '0;
      seen_point   <= 1'b0;
      id_bad       <= 1'b0;
      fld_len      <= '0;
      fld_first    <= '0;
      fld_bad      <= 1'b0;
      rec          <= '0;
    end else if (accept) begin
      if (rx_byte == nrmc_pkg::CH_LF) begin
        field_number <= '0;
        line_count   <= '0;
        acc          <= '0;
        frac_digits  <= '0;
        seen_point   <= 1'b0;
        id_bad       <= 1'b0;
        fld_len      <= '0;
        fld_first    <= '0;
        fld_bad      <= 1'b0;
        rec          <= '0;
      end else if (rx_byte != nrmc_pkg::CH_CR &&
                   line_count < nrmc_pkg::LC_W'(nrmc_pkg::MAX_LINE - 1)) begin
        line_count <= line_count + 1'b1;
        if (rx_byte == nrmc_pkg::CH_COMMA) begin
          rec <= rec_fin;
          if (field_number != nrmc_pkg::FLD_LAST) field_number <= field_number + 1'b1;
          acc         <= '0;
          frac_digits <= '0;
          seen_point  <= 1'b0;
          fld_len     <= '0;
          fld_first   <= '0;
          fld_bad     <= 1'b0;
        end else begin
          if (fld_len == 3'd0) fld_first <= rx_byte;
          if (field_number == nrmc_pkg::FLD_ID) begin
            if (fld_len >= 3'd6 || nrmc_pkg::rmc_id_char(fld_len) != rx_byte) id_bad <= 1'b1;
          end else if (is_digit) begin
            if (!seen_point || frac_digits < 3'(nrmc_pkg::FRAC_DIGITS)) begin
              acc <= acc_next;
              if (seen_point) frac_digits <= frac_digits + 1'b1;
            end
          end else if (rx_byte == nrmc_pkg::CH_DOT) begin
            if (seen_point) fld_bad <= 1'b1;
            seen_point <= 1'b1;
          end else begin
            fld_bad <= 1'b1;
          end
          if (fld_len != 3'd7) fld_len <= fld_len + 1'b1;
        end
      end
    end
  end

  // Finished line record, first pipeline stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_vld <= 1'b0;
    end else if (adv) begin
      line_vld <= accept && (rx_byte == nrmc_pkg::CH_LF);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && accept && rx_byte == nrmc_pkg::CH_LF) line_rec <= rec_fin;
  end

endmodule

[rtl/core/nrmc_convert.sv]
// ----------------------------------------------------------------------------
// nrmc_convert: fixed-point conversion pipeline
// Five stages turn raw scaled field values into time and heading in
// hundredths, position in 1e-7 degrees and speed in 0.01 km/h.
// ----------------------------------------------------------------------------
module nrmc_convert (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_vld,
  input  nrmc_pkg::line_t    in_rec,
  output logic               out_vld,
  output nrmc_pkg::conv_t    out_rec
);

  localparam int PV_W  = 2 * nrmc_pkg::V_W + 1;
  localparam int P6_W  = 2 * nrmc_pkg::N_W + 1;
  localparam int P2_W  = 2 * nrmc_pkg::N2_W + 1;

  // Stage 1: reciprocal products.
  logic                        vld1;
  nrmc_pkg::flags_t            flg1;
  logic [PV_W-1:0]             t_prod1, h_prod1, lat_prod1, lon_prod1, spd_prod1;
  logic [nrmc_pkg::V_W-1:0]    lat_raw1, lon_raw1, spd_raw1;
  logic                        lat_big1, lon_big1, spd_big1;

  // Stage 2: quotients and remainders.
  logic                        vld2;
  nrmc_pkg::flags_t            flg2;
  logic [24:0]                 time2;
  logic [15:0]                 hdg2;
  logic [nrmc_pkg::DEG_W-1:0]  lat_deg2, lon_deg2;
  logic [nrmc_pkg::M_W-1:0]    lat_m2, lon_m2;
  logic [nrmc_pkg::VH_W-1:0]   spd_vh2;
  logic [nrmc_pkg::VL_W-1:0]   spd_vl2;
  logic                        lat_big2, lon_big2, spd_big2;

  // Stage 3: rounding numerators.
  logic                        vld3;
  nrmc_pkg::flags_t            flg3;
  logic [24:0]                 time3;
  logic [15:0]                 hdg3;
  logic [nrmc_pkg::DEG_W-1:0]  lat_deg3, lon_deg3;
  logic [nrmc_pkg::N_W-1:0]    lat_n3, lon_n3;
  logic [nrmc_pkg::VH_W-1:0]   spd_vh3;
  logic [nrmc_pkg::N2_W-1:0]   spd_n3;
  logic                        lat_big3, lon_big3, spd_big3;

  // Stage 4: reciprocal products of the numerators.
  logic                        vld4;
  nrmc_pkg::flags_t            flg4;
  logic [24:0]                 time4;
  logic [15:0]                 hdg4;
  logic [nrmc_pkg::DEG_W-1:0]  lat_deg4, lon_deg4;
  logic [P6_W-1:0]             lat_qp4, lon_qp4;
  logic [nrmc_pkg::VH_W-1:0]   spd_vh4;
  logic [P2_W-1:0]             spd_qp4;
  logic                        lat_big4, lon_big4, spd_big4;

  logic [nrmc_pkg::V_W-1:0]    t_q, h_q;
  logic [nrmc_pkg::DEG_W-1:0]  lat_deg, lon_deg;
  logic [nrmc_pkg::VH_W-1:0]   spd_vh;
  logic [nrmc_pkg::N_W-1:0]    lat_q, lon_q;
  logic [nrmc_pkg::N2_W-1:0]   spd_q;
  logic [35:0]                 lat_r, lon_r;
  logic [23:0]                 spd_r;

  // Stage 2 combinational: quotients.
  always_comb begin
    t_q     = nrmc_pkg::V_W'(t_prod1 >> nrmc_pkg::T_SH);
    h_q     = nrmc_pkg::V_W'(h_prod1 >> nrmc_pkg::T_SH);
    lat_deg = nrmc_pkg::DEG_W'(lat_prod1 >> nrmc_pkg::D_SH);
    lon_deg = nrmc_pkg::DEG_W'(lon_prod1 >> nrmc_pkg::D_SH);
    spd_vh  = nrmc_pkg::VH_W'(spd_prod1 >> nrmc_pkg::S1_SH);
  end

  // Stage 5 combinational: final sums.
  always_comb begin
    lat_q = nrmc_pkg::N_W'(lat_qp4 >> nrmc_pkg::Q6_SH);
    lon_q = nrmc_pkg::N_W'(lon_qp4 >> nrmc_pkg::Q6_SH);
    spd_q = nrmc_pkg::N2_W'(spd_qp4 >> nrmc_pkg::S2_SH);
    lat_r = 36'(64'(lat_deg4) * nrmc_pkg::DEG_SCALE + 64'(lat_q));
    lon_r = 36'(64'(lon_deg4) * nrmc_pkg::DEG_SCALE + 64'(lon_q));
    spd_r = 24'(spd_vh4) * 24'd1852 + 24'(spd_q);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      vld3    <= vld2;
      vld4    <= vld3;
      out_vld <= vld4;
    end
  end

  // Data path.
  always_ff @(posedge clk) begin
    if (adv) begin
      flg1      <= in_rec.flags;
      t_prod1   <= PV_W'(in_rec.time_raw) * PV_W'(nrmc_pkg::T_MUL);
      h_prod1   <= PV_W'(in_rec.hdg_raw) * PV_W'(nrmc_pkg::T_MUL);
      lat_prod1 <= PV_W'(in_rec.lat_raw) * PV_W'(nrmc_pkg::D_MUL);
      lon_prod1 <= PV_W'(in_rec.lon_raw) * PV_W'(nrmc_pkg::D_MUL);
      spd_prod1 <= PV_W'(in_rec.spd_raw) * PV_W'(nrmc_pkg::S1_MUL);
      lat_raw1  <= in_rec.lat_raw;
      lon_raw1  <= in_rec.lon_raw;
      spd_raw1  <= in_rec.spd_raw;
      lat_big1  <= 64'(in_rec.lat_raw) >= nrmc_pkg::DEG_LIM;
      lon_big1  <= 64'(in_rec.lon_raw) >= nrmc_pkg::DEG_LIM;
      spd_big1  <= 64'(in_rec.spd_raw) >= nrmc_pkg::SPD_LIM;

      flg2     <= flg1;
      time2    <= (64'(t_q) > nrmc_pkg::TIME_MAX) ? 25'(nrmc_pkg::TIME_MAX) : 25'(t_q);
      hdg2     <= (64'(h_q) > nrmc_pkg::HEAD_MAX) ? 16'(nrmc_pkg::HEAD_MAX) : 16'(h_q);
      lat_deg2 <= lat_deg;
      lon_deg2 <= lon_deg;
      lat_m2   <= nrmc_pkg::M_W'(lat_raw1 - nrmc_pkg::V_W'(64'(lat_deg) * nrmc_pkg::DEG_D));
      lon_m2   <= nrmc_pkg::M_W'(lon_raw1 - nrmc_pkg::V_W'(64'(lon_deg) * nrmc_pkg::DEG_D));
      spd_vh2  <= spd_vh;
      spd_vl2  <= nrmc_pkg::VL_W'(spd_raw1 - nrmc_pkg::V_W'(64'(spd_vh) * nrmc_pkg::SPD_D));
      lat_big2 <= lat_big1;
      lon_big2 <= lon_big1;
      spd_big2 <= spd_big1;

      flg3     <= flg2;
      time3    <= time2;
      hdg3     <= hdg2;
      lat_deg3 <= lat_deg2;
      lon_deg3 <= lon_deg2;
      lat_n3   <= nrmc_pkg::N_W'(64'(lat_m2) * nrmc_pkg::DEG_K + 64'd3);
      lon_n3   <= nrmc_pkg::N_W'(64'(lon_m2) * nrmc_pkg::DEG_K + 64'd3);
      spd_vh3  <= spd_vh2;
      spd_n3   <= nrmc_pkg::N2_W'(64'(spd_vl2) * 64'd463 + nrmc_pkg::SPD_RND);
      lat_big3 <= lat_big2;
      lon_big3 <= lon_big2;
      spd_big3 <= spd_big2;

      flg4     <= flg3;
      time4    <= time3;
      hdg4     <= hdg3;
      lat_deg4 <= lat_deg3;
      lon_deg4 <= lon_deg3;
      lat_qp4  <= P6_W'(lat_n3) * P6_W'(nrmc_pkg::Q6_MUL);
      lon_qp4  <= P6_W'(lon_n3) * P6_W'(nrmc_pkg::Q6_MUL);
      spd_vh4  <= spd_vh3;
      spd_qp4  <= P2_W'(spd_n3) * P2_W'(nrmc_pkg::S2_MUL);
      lat_big4 <= lat_big3;
      lon_big4 <= lon_big3;
      spd_big4 <= spd_big3;

      out_rec.flags   <= flg4;
      out_rec.time_c  <= time4;
      out_rec.hdg_c   <= hdg4;
      out_rec.lat_mag <= (lat_big4 || 64'(lat_r) > nrmc_pkg::LAT_MAX) ?
                         30'(nrmc_pkg::LAT_MAX) : 30'(lat_r);
      out_rec.lon_mag <= (lon_big4 || 64'(lon_r) > nrmc_pkg::LON_MAX) ?
                         31'(nrmc_pkg::LON_MAX) : 31'(lon_r);
      out_rec.spd_c   <= (spd_big4 || 64'(spd_r) > nrmc_pkg::SPEED_MAX) ?
                         21'(nrmc_pkg::SPEED_MAX) : 21'(spd_r);
    end
  end

endmodule

[rtl/core/nrmc_result.sv]
// ----------------------------------------------------------------------------
// nrmc_result: line status decision, fix holds and output register
// Classifies each converted line, updates the held fix on a valid line
// and registers the result word.
// ----------------------------------------------------------------------------
module nrmc_result (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_vld,
  input  nrmc_pkg::conv_t     in_rec,
  output logic                out_valid,
  output logic [1:0]          status,
  output logic [24:0]         utc_time_centi,
  output logic signed [30:0]  latitude_e7,
  output logic signed [31:0]  longitude_e7,
  output logic [20:0]         speed_kmh_centi,
  output logic [15:0]         heading_centi
);

  logic [24:0]         time_hold, time_hold_next;
  logic signed [30:0]  lat_hold, lat_hold_next;
  logic signed [31:0]  lon_hold, lon_hold_next;
  logic [20:0]         speed_hold, speed_hold_next;
  logic [15:0]         heading_hold, heading_hold_next;
  logic [1:0]          status_next;
  logic [24:0]         time_out;

  // Status decision and hold update.
  always_comb begin
    time_hold_next    = time_hold;
    lat_hold_next     = lat_hold;
    lon_hold_next     = lon_hold;
    speed_hold_next   = speed_hold;
    heading_hold_next = heading_hold;
    time_out          = time_hold;
    if (!in_rec.flags.prefix) begin
      status_next = nrmc_pkg::ST_NOT_RMC;
    end else if (!in_rec.flags.time_ok || in_rec.flags.time_bad) begin
      status_next = nrmc_pkg::ST_MALFORMED;
    end else if (!in_rec.flags.fix) begin
      status_next = nrmc_pkg::ST_VOID;
      time_out    = in_rec.time_c;
    end else if (!in_rec.flags.lat_ok || !in_rec.flags.lon_ok || in_rec.flags.err) begin
      status_next = nrmc_pkg::ST_MALFORMED;
    end else begin
      status_next    = nrmc_pkg::ST_VALID;
      time_hold_next = in_rec.time_c;
      lat_hold_next  = in_rec.flags.lat_s ? -$signed({1'b0, in_rec.lat_mag}) :
                                             $signed({1'b0, in_rec.lat_mag});
      lon_hold_next  = in_rec.flags.lon_w ? -$signed({1'b0, in_rec.lon_mag}) :
                                             $signed({1'b0, in_rec.lon_mag});
      if (in_rec.flags.spd_ok) speed_hold_next = in_rec.spd_c;
      if (in_rec.flags.hdg_ok) heading_hold_next = in_rec.hdg_c;
      time_out = in_rec.time_c;
    end
  end

  // Holds and output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      time_hold    <= '0;
      lat_hold     <= '0;
      lon_hold     <= '0;
      speed_hold   <= '0;
      heading_hold <= '0;
    end else if (adv) begin
      out_valid <= in_vld;
      if (in_vld) begin
        time_hold    <= time_hold_next;
        lat_hold     <= lat_hold_next;
        lon_hold     <= lon_hold_next;
        speed_hold   <= speed_hold_next;
        heading_hold <= heading_hold_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_vld) begin
      status          <= status_next;
      utc_time_centi  <= time_out;
      latitude_e7     <= lat_hold_next;
      longitude_e7    <= lon_hold_next;
      speed_kmh_centi <= speed_hold_next;
      heading_centi   <= heading_hold_next;
    end
  end

endmodule

[verif/nmea_rmc_sentence_parser_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser_unit_tb: self-checking bench of the RMC parser
// Feeds NMEA text byte by byte: a directed table of sentences first, then
// random well-formed, damaged and noise sentences. Every result word is
// compared with a software parser that tracks the same line and fix state.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser_unit_tb;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic [24:0]        utc_time_centi;
  logic signed [30:0] latitude_e7;
  logic signed [31:0] longitude_e7;
  logic [20:0]        speed_kmh_centi;
  logic [15:0]        heading_centi;

  nmea_rmc_sentence_parser_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .utc_time_centi(utc_time_centi),
    .latitude_e7(latitude_e7), .longitude_e7(longitude_e7),
    .speed_kmh_centi(speed_kmh_centi), .heading_centi(heading_centi)
  );

  typedef struct {
    logic [1:0]         st;
    logic [24:0]        tm;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic [20:0]        spd;
    logic [15:0]        hdg;
  } fix_word_t;

  localparam longint unsigned ACC_LIMIT = 64'd999999999999;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_COUNT  = 1400;
  localparam int QUIET_FROM  = 1200;

  fix_word_t fix_queue[$];
  int        failures;
  int        cycle_count;
  int        sent_count;
  bit        quiet_mode;

  // Parser state of the software predictor.
  bit              p_prefix, p_id_bad, p_seen_pt, p_fld_bad, p_fix, p_err;
  int              p_field, p_count, p_frac, p_len;
  logic [7:0]      p_first;
  longint unsigned p_acc;
  bit              p_time_ok, p_time_bad, p_lat_ok, p_lat_s, p_lon_ok, p_lon_w;
  bit              p_spd_ok, p_hdg_ok;
  longint unsigned p_time_v, p_spd_v, p_hdg_v;
  longint          p_lat_v, p_lon_v;
  longint unsigned h_time, h_spd, h_hdg;
  longint          h_lat, h_lon;

  // Clock and cycle limit.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint unsigned pow10_of(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  function automatic longint unsigned centi_of(input longint unsigned v,
                                               input longint unsigned maxv);
    longint unsigned r;
    r = v / (pow10_of(nrmc_pkg::FRAC_DIGITS) / 100);
    return (r > maxv) ? maxv : r;
  endfunction

  function automatic longint degrees_e7(input longint unsigned v, input longint unsigned maxv);
    longint unsigned pw, deg, mins, r;
    pw   = pow10_of(nrmc_pkg::FRAC_DIGITS);
    deg  = v / (100 * pw);
    mins = v - deg * 100 * pw;
    if (deg >= 1000) return longint'(maxv);
    r = deg * 10000000 + (mins * 10000000 + 30 * pw) / (60 * pw);
    if (r > maxv) r = maxv;
    return longint'(r);
  endfunction

  function automatic longint unsigned kmh_centi(input longint unsigned v);
    longint unsigned pw, r;
    pw = pow10_of(nrmc_pkg::FRAC_DIGITS);
    if (v >= 10000 * pw) return nrmc_pkg::SPEED_MAX;
    r = (v * 1852 + 5 * pw) / (10 * pw);
    return (r > nrmc_pkg::SPEED_MAX) ? nrmc_pkg::SPEED_MAX : r;
  endfunction

  task automatic clear_field_state();
    p_acc = 0; p_frac = 0; p_seen_pt = 0; p_len = 0; p_first = 8'd0; p_fld_bad = 0;
  endtask

  task automatic clear_line_state();
    clear_field_state();
    p_prefix = 0; p_field = 0; p_count = 0; p_fix = 0; p_err = 0; p_id_bad = 0;
    p_time_ok = 0; p_time_bad = 0; p_lat_ok = 0; p_lat_s = 0; p_lon_ok = 0;
    p_lon_w = 0; p_spd_ok = 0; p_hdg_ok = 0;
    p_time_v = 0; p_spd_v = 0; p_hdg_v = 0; p_lat_v = 0; p_lon_v = 0;
  endtask

  // Close the current field and stage its value by position.
  task automatic close_field();
    bit present;
    longint unsigned v;
    present = (p_len != 0);
    v = p_acc;
    for (int i = p_frac; i < nrmc_pkg::FRAC_DIGITS; i++) v = v * 10;
    if ((p_field == nrmc_pkg::FLD_LAT || p_field == nrmc_pkg::FLD_LON ||
         p_field == nrmc_pkg::FLD_SPEED || p_field == nrmc_pkg::FLD_COURSE) &&
        p_fld_bad) p_err = 1;
    case (p_field)
      nrmc_pkg::FLD_ID:     p_prefix = !p_id_bad && p_len == 6;
      nrmc_pkg::FLD_TIME:   begin
        p_time_ok  = present;
        p_time_bad = p_fld_bad;
        p_time_v   = centi_of(v, nrmc_pkg::TIME_MAX);
      end
      nrmc_pkg::FLD_STATUS: p_fix = present && p_first == nrmc_pkg::CH_A;
      nrmc_pkg::FLD_LAT:    begin
        p_lat_ok = present; p_lat_v = degrees_e7(v, nrmc_pkg::LAT_MAX);
      end
      nrmc_pkg::FLD_NS:     p_lat_s = present && p_first == nrmc_pkg::CH_S;
      nrmc_pkg::FLD_LON:    begin
        p_lon_ok = present; p_lon_v = degrees_e7(v, nrmc_pkg::LON_MAX);
      end
      nrmc_pkg::FLD_EW:     p_lon_w = present && p_first == nrmc_pkg::CH_W;
      nrmc_pkg::FLD_SPEED:  begin p_spd_ok = present; p_spd_v = kmh_centi(v); end
      nrmc_pkg::FLD_COURSE: begin
        p_hdg_ok = present; p_hdg_v = centi_of(v, nrmc_pkg::HEAD_MAX);
      end
      default: ;
    endcase
  endtask

  // Predict the result of one byte; a line end queues one result word.
  task automatic predict_byte(input logic [7:0] c);
    fix_word_t w;
    logic [7:0] id_chars[6];
    id_chars = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};
    if (c == nrmc_pkg::CH_CR) return;
    if (c == nrmc_pkg::CH_LF) begin
      close_field();
      w.tm = h_time;
      if (!p_prefix) w.st = nrmc_pkg::ST_NOT_RMC;
      else if (!p_time_ok || p_time_bad) w.st = nrmc_pkg::ST_MALFORMED;
      else if (!p_fix) begin
        w.st = nrmc_pkg::ST_VOID;
        w.tm = p_time_v;
      end else if (!p_lat_ok || !p_lon_ok || p_err) w.st = nrmc_pkg::ST_MALFORMED;
      else begin
        w.st = nrmc_pkg::ST_VALID;
        h_time = p_time_v;
        h_lat = p_lat_s ? -p_lat_v : p_lat_v;
        h_lon = p_lon_w ? -p_lon_v : p_lon_v;
        if (p_spd_ok) h_spd = p_spd_v;
        if (p_hdg_ok) h_hdg = p_hdg_v;
        w.tm = h_time;
      end
      w.lat = h_lat[30:0];
      w.lon = h_lon[31:0];
      w.spd = h_spd[20:0];
      w.hdg = h_hdg[15:0];
      fix_queue.push_back(w);
      clear_line_state();
      return;
    end
    if (p_count >= nrmc_pkg::MAX_LINE - 1) return;
    p_count++;
    if (c == nrmc_pkg::CH_COMMA) begin
      close_field();
      if (p_field < 15) p_field++;
      clear_field_state();
      return;
    end
    if (p_len == 0) p_first = c;
    if (p_field == 0) begin
      if (p_len >= 6 || id_chars[p_len] != c) p_id_bad = 1;
    end else if (c >= nrmc_pkg::CH_0 && c <= nrmc_pkg::CH_9) begin
      if (!p_seen_pt || p_frac < nrmc_pkg::FRAC_DIGITS) begin
        p_acc = p_acc * 10 + (c - nrmc_pkg::CH_0);
        if (p_acc > ACC_LIMIT) p_acc = ACC_LIMIT;
        if (p_seen_pt) p_frac++;
      end
    end else if (c == nrmc_pkg::CH_DOT) begin
      if (p_seen_pt) p_fld_bad = 1;
      p_seen_pt = 1;
    end else begin
      p_fld_bad = 1;
    end
    if (p_len < 255) p_len++;
  endtask

  // Send one byte word, outside quiet mode sometimes with a random gap before it.
  task automatic send_byte(input logic [7:0] c);
    if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(c);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Random digits with an optional fraction of random length.
  function automatic string digit_run(input int int_len, input int frac_max);
    string s;
    int n;
    s = "";
    for (int i = 0; i < int_len; i++)
      s = {s, string'(8'(nrmc_pkg::CH_0 + $urandom_range(0, 9)))};
    if (frac_max > 0 && $urandom_range(0, 3) != 0) begin
      n = $urandom_range(0, frac_max);
      s = {s, "."};
      for (int i = 0; i < n; i++)
        s = {s, string'(8'(nrmc_pkg::CH_0 + $urandom_range(0, 9)))};
    end
    return s;
  endfunction

  // Occasionally damage or blank a field.
  function automatic string maybe_break(input string s);
    int k;
    k = $urandom_range(0, 29);
    if (k == 0) return "";
    if (k == 1) return {s, "x"};
    if (k == 2) return {s, ".."};
    if (k == 3) return {s, string'(8'($urandom_range(0, 255)))};
    return s;
  endfunction

  function automatic string random_sentence();
    string s, id, fx, ns, ew;
    int k;
    k  = $urandom_range(0, 19);
    id = (k == 0) ? "$GPGGA" : (k == 1) ? "$GPRMCX" : (k == 2) ? "" : "$GPRMC";
    fx = ($urandom_range(0, 4) == 0) ? "V" : "A";
    ns = ($urandom_range(0, 1) != 0) ? "S" : "N";
    ew = ($urandom_range(0, 1) != 0) ? "W" : "E";
    s = {id, ",", maybe_break(digit_run($urandom_range(5, 7), 4)), ",",
         maybe_break(fx), ",", maybe_break(digit_run($urandom_range(3, 6), 6)), ",",
         maybe_break(ns), ",", maybe_break(digit_run($urandom_range(4, 6), 6)), ",",
         maybe_break(ew), ",", maybe_break(digit_run($urandom_range(0, 5), 5)), ",",
         maybe_break(digit_run($urandom_range(0, 5), 5))};
    k = $urandom_range(0, 9);
    if (k == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
    else if (k == 1) s = {s, ",230394,003.1,W*6A"};
    if ($urandom_range(0, 1) != 0) s = {s, "\r"};
    return s;
  endfunction

  // Receiver side: random stall and checking of result words.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet_mode && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    fix_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (fix_queue.size() == 0) begin
        $error("result word with nothing expected");
        failures++;
      end else begin
        w = fix_queue.pop_front();
        if (status !== w.st) begin
          $error("status: expected %0d actual %0d", w.st, status); failures++;
        end
        if (utc_time_centi !== w.tm) begin
          $error("utc_time_centi: expected %0d actual %0d", w.tm, utc_time_centi);
          failures++;
        end
        if (latitude_e7 !== w.lat) begin
          $error("latitude_e7: expected %0d actual %0d", w.lat, latitude_e7); failures++;
        end
        if (longitude_e7 !== w.lon) begin
          $error("longitude_e7: expected %0d actual %0d", w.lon, longitude_e7);
          failures++;
        end
        if (speed_kmh_centi !== w.spd) begin
          $error("speed_kmh_centi: expected %0d actual %0d", w.spd, speed_kmh_centi);
          failures++;
        end
        if (heading_centi !== w.hdg) begin
          $error("heading_centi: expected %0d actual %0d", w.hdg, heading_centi);
          failures++;
        end
      end
    end
  end

  // Directed sentences; for a row marked fixed, the line end checks the predicted status against the given code.
  typedef struct {
    string      text;
    bit         fixed;
    logic [1:0] st;
  } line_row_t;

  line_row_t line_table[] = '{
    '{"", 1, nrmc_pkg::ST_NOT_RMC},
    '{"$GPRMC,235959.99,A,9000.0000,N,18000.0000,E,1000,360", 0, nrmc_pkg::ST_VALID},
    '{"$GPRMC,000000,A,0000.0000,S,00000.0000,W,0,0", 0, nrmc_pkg::ST_VALID},
    '{"$GPRMC,123519,A,4807.038,S,01131.000,W,022.4,084.4\r", 1, nrmc_pkg::ST_VALID},
    '{"$GPRMC,123519,V,4807.038,N,01131.000,E,,", 1, nrmc_pkg::ST_VOID},
    '{"$GPRMC,,A,4807.038,N,01131.000,E,,", 1, nrmc_pkg::ST_MALFORMED},
    '{"$GPRMC,12a519,A,4807.038,N,01131.000,E,,", 1, nrmc_pkg::ST_MALFORMED},
    '{"$GPRMC,123519,A,,N,01131.000,E,,", 1, nrmc_pkg::ST_MALFORMED},
    '{"$GPRMC,123519,A,4807.038,N,01131.000,E,1..2,", 1, nrmc_pkg::ST_MALFORMED},
    '{"$GPRMC,123519,V,48x7,N,01131.000,E,abc,", 1, nrmc_pkg::ST_VOID},
    '{"$GPGGA,123519,A,4807.038,N,01131.000,E,,", 1, nrmc_pkg::ST_NOT_RMC},
    '{"$GPRMC", 1, nrmc_pkg::ST_MALFORMED},
    '{"$GPRMC,1", 1, nrmc_pkg::ST_VOID},
    '{"$GPRMC,999999.9999,A,99999.99999,N,999999.99999,E,99999999999999,99999", 0,
      nrmc_pkg::ST_VALID},
    '{"$GPRMC,101010,A,1234.5678,N,12345.6789,E,12.34567,,extra,1,2,3,4,5,6,7", 0,
      nrmc_pkg::ST_VALID},
    '{"\x80\xff\x00,\x7f", 1, nrmc_pkg::ST_NOT_RMC}
  };

  initial begin
    string s;
    failures    = 0;
    cycle_count = 0;
    sent_count  = 0;
    quiet_mode  = 1'b0;
    h_time = 0; h_spd = 0; h_hdg = 0; h_lat = 0; h_lon = 0;
    clear_line_state();
    rst      = 1'b1;
    in_valid = 1'b0;
    rx_byte  = 8'd0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed part, plus one line longer than the line limit.
    foreach (line_table[i]) begin
      if (line_table[i].fixed) begin
        if (line_table[i].text != "") send_text(line_table[i].text);
        send_byte(nrmc_pkg::CH_LF);
        if (fix_queue[$].st !== line_table[i].st) begin
          $error("status: expected %0d from table, predictor %0d",
                 line_table[i].st, fix_queue[$].st);
          failures++;
        end
      end else begin
        send_text(line_table[i].text);
        send_byte(nrmc_pkg::CH_LF);
      end
    end
    s = "$GPRMC,101010,A,1234.5678,N,12345.6789,E,1,2";
    while (s.len() < nrmc_pkg::MAX_LINE + 20) s = {s, ",9"};
    send_text(s);
    send_byte(nrmc_pkg::CH_LF);

    // Hold the sender until every result word is out.
    in_valid <= 1'b0;
    while (fix_queue.size() != 0) @(negedge clk);

    // Random part: sentences with random content, and raw noise.
    while (sent_count < ITEM_COUNT) begin
      if (sent_count >= QUIET_FROM) quiet_mode = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
        send_byte(nrmc_pkg::CH_LF);
      end else begin
        send_text(random_sentence());
        send_byte(nrmc_pkg::CH_LF);
      end
    end
    in_valid <= 1'b0;

    while (fix_queue.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
